/* rtl/core/hct_pkg.sv */
// ----------------------------------------------------------------------------
// hct_pkg: shared types and constants
// Payload structs, step codes, register indexes and widths for the hall
// commutation and speed tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package hct_pkg;

  localparam int TICK_BITS    = 16;
  localparam int SUBTICK_BITS = 24;
  localparam int HALL_BITS    = 3;
  localparam int HALL_ENTRIES = 6;
  localparam int TABLE_BITS   = HALL_BITS * HALL_ENTRIES;
  localparam int CFG_BITS     = 24;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [SUBTICK_BITS-1:0] SUBTICKS_RESET = 24'd72000;

  localparam logic [CFG_IDX_BITS-1:0] CFG_HALL_TABLE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FORWARD    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DRIVE_EN   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SUBTICKS   = 2'd3;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_HALL = 1'b1;

  typedef enum logic [1:0] {
    STEP_NONE    = 2'd0,
    STEP_FORWARD = 2'd1,
    STEP_REVERSE = 2'd2,
    STEP_INVALID = 2'd3
  } step_kind_t;

  typedef struct packed {
    logic                    operation;
    logic [HALL_BITS-1:0]    hall_code;
    logic [SUBTICK_BITS-1:0] subtick_now;
  } hct_in_t;

  typedef struct packed {
    step_kind_t              step_kind;
    logic signed [31:0]      position;
    logic [15:0]             period_ticks;
    logic [SUBTICK_BITS-1:0] period_subticks;
    logic                    period_fresh;
    logic                    drive_update;
    logic [2:0]              drive_pair;
    logic                    hall_fault;
  } hct_out_t;

  typedef struct packed {
    step_kind_t kind;
    logic       drive_hit;
    logic [2:0] drive_sel;
  } hct_decode_t;

endpackage

`default_nettype wire

/* rtl/core/hall_commutation_speed_tracker_top.sv */
// ----------------------------------------------------------------------------
// hall_commutation_speed_tracker_top: six-step hall tracker
// Result path: the input transfer loads the input register, then one
// state-update pass loads the result register once the output can advance.
// Throughput: one item per cycle while out_stall is low (one update pass).
// Reset: synchronous rst clears all tracking state and loads the register
// defaults (sub-tick span 72000, everything else zero).
// ----------------------------------------------------------------------------
`default_nettype none

module hall_commutation_speed_tracker_top
  import hct_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire hct_in_t                 in_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output hct_out_t                     out_data
);

  logic [TABLE_BITS-1:0]   hall_table;
  logic                    forward_command;
  logic                    drive_enable;
  logic [SUBTICK_BITS-1:0] subticks_per_tick;

  logic [HALL_BITS-1:0]    previous_hall;
  logic                    timing_armed;
  logic [TICK_BITS-1:0]    elapsed_ticks;
  logic [SUBTICK_BITS-1:0] start_subtick;
  logic [TICK_BITS-1:0]    last_period_ticks;
  logic [SUBTICK_BITS-1:0] last_period_subticks;
  logic signed [31:0]      step_position;
  logic                    fault_flag;
  logic [2:0]              current_drive;

  logic [HALL_BITS-1:0]    previous_hall_next;
  logic                    timing_armed_next;
  logic [TICK_BITS-1:0]    elapsed_ticks_next;
  logic [SUBTICK_BITS-1:0] start_subtick_next;
  logic [TICK_BITS-1:0]    last_period_ticks_next;
  logic [SUBTICK_BITS-1:0] last_period_subticks_next;
  logic signed [31:0]      step_position_next;
  logic                    fault_flag_next;
  logic [2:0]              current_drive_next;
  logic                    fresh;
  logic                    drive_update;
  step_kind_t              kind;

  hct_in_t                 in_q;
  logic                    in_q_valid;
  logic                    advance;
  logic                    process;
  hct_out_t                out_next;
  hct_decode_t             decode;

  logic                    dir_matches;
  logic                    start_ge_end;
  logic [SUBTICK_BITS-1:0] sub_direct;
  logic [SUBTICK_BITS-1:0] sub_borrow;
  logic [TICK_BITS-1:0]    meas_ticks;
  logic [SUBTICK_BITS-1:0] meas_subticks;

  // handshake
  assign advance  = !out_valid || !out_stall;
  assign process  = in_q_valid && advance;
  assign in_stall = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (process) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      hall_table        <= '0;
      forward_command   <= 1'b0;
      drive_enable      <= 1'b0;
      subticks_per_tick <= SUBTICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HALL_TABLE: hall_table        <= cfg_data[TABLE_BITS-1:0];
        CFG_FORWARD:    forward_command   <= cfg_data[0];
        CFG_DRIVE_EN:   drive_enable      <= cfg_data[0];
        CFG_SUBTICKS:   subticks_per_tick <= cfg_data[SUBTICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  hct_hall_decode u_decode (
    .hall_table      (hall_table),
    .prev_hall       (previous_hall),
    .hall_code       (in_q.hall_code),
    .forward_command (forward_command),
    .drive_enable    (drive_enable),
    .decode          (decode)
  );

  // period measurement: borrow a tick when ticks elapsed and end is above start
  assign start_ge_end = (start_subtick >= in_q.subtick_now);
  assign sub_direct   = start_subtick - in_q.subtick_now;
  assign sub_borrow   = start_subtick + subticks_per_tick - in_q.subtick_now;

  always_comb begin
    if (elapsed_ticks == '0) begin
      meas_ticks    = '0;
      meas_subticks = sub_direct;
    end else if (start_ge_end) begin
      meas_ticks    = elapsed_ticks;
      meas_subticks = sub_direct;
    end else begin
      meas_ticks    = elapsed_ticks - 1'b1;
      meas_subticks = sub_borrow;
    end
  end

  assign dir_matches = (forward_command == (decode.kind == STEP_FORWARD));

  always_comb begin
    previous_hall_next        = previous_hall;
    timing_armed_next         = timing_armed;
    elapsed_ticks_next        = elapsed_ticks;
    start_subtick_next        = start_subtick;
    last_period_ticks_next    = last_period_ticks;
    last_period_subticks_next = last_period_subticks;
    step_position_next        = step_position;
    fault_flag_next           = fault_flag;
    current_drive_next        = current_drive;
    fresh                     = 1'b0;
    drive_update              = 1'b0;
    kind                      = STEP_NONE;
    if (in_q.operation == OP_TICK) begin
      elapsed_ticks_next = elapsed_ticks + 1'b1;
    end else begin
      kind               = decode.kind;
      previous_hall_next = in_q.hall_code;
      if (decode.kind == STEP_INVALID) begin
        fault_flag_next = 1'b1;
      end else begin
        if (decode.kind == STEP_FORWARD) begin
          step_position_next = step_position + 32'sd1;
        end else begin
          step_position_next = step_position - 32'sd1;
        end
        if (!dir_matches) begin
          timing_armed_next = 1'b0;
        end else if (!timing_armed) begin
          timing_armed_next  = 1'b1;
          elapsed_ticks_next = '0;
          start_subtick_next = in_q.subtick_now;
        end else begin
          timing_armed_next         = 1'b0;
          last_period_ticks_next    = meas_ticks;
          last_period_subticks_next = meas_subticks;
          fresh                     = 1'b1;
        end
      end
      if (decode.drive_hit) begin
        current_drive_next = decode.drive_sel;
        drive_update       = 1'b1;
      end
    end
  end

  always_comb begin
    out_next.step_kind       = kind;
    out_next.position        = step_position_next;
    out_next.period_ticks    = 16'(last_period_ticks_next);
    out_next.period_subticks = last_period_subticks_next;
    out_next.period_fresh    = fresh;
    out_next.drive_update    = drive_update;
    out_next.drive_pair      = current_drive_next;
    out_next.hall_fault      = fault_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_hall        <= '0;
      timing_armed         <= 1'b0;
      elapsed_ticks        <= '0;
      start_subtick        <= '0;
      last_period_ticks    <= '0;
      last_period_subticks <= '0;
      step_position        <= '0;
      fault_flag           <= 1'b0;
      current_drive        <= '0;
    end else if (process) begin
      previous_hall        <= previous_hall_next;
      timing_armed         <= timing_armed_next;
      elapsed_ticks        <= elapsed_ticks_next;
      start_subtick        <= start_subtick_next;
      last_period_ticks    <= last_period_ticks_next;
      last_period_subticks <= last_period_subticks_next;
      step_position        <= step_position_next;
      fault_flag           <= fault_flag_next;
      current_drive        <= current_drive_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_data <= out_next;
    end
  end

`ifndef SYNTHESIS
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    fault_flag |=> fault_flag)
    else $error("hall fault flag cleared without reset");

  a_fresh_on_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.period_fresh |->
      (out_data.step_kind == STEP_FORWARD || out_data.step_kind == STEP_REVERSE))
    else $error("period measured on a non-step item");

  a_update_on_hall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drive_update |-> out_data.step_kind != STEP_NONE)
    else $error("drive updated on a tick");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    current_drive <= 3'd5)
    else $error("drive pair out of range");

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_q_valid && out_valid)
    else $error("input stalled with room to take a transfer");
`endif

endmodule

`default_nettype wire

/* rtl/core/hct_hall_decode.sv */
// ----------------------------------------------------------------------------
// hct_hall_decode: hall step classifier and drive selector
// Finds the previous code in the rotation table, classifies the new code as
// forward, reverse or invalid, and picks the phase pair for the new code.
// ----------------------------------------------------------------------------
`default_nettype none

module hct_hall_decode
  import hct_pkg::*;
(
  input  wire logic [TABLE_BITS-1:0] hall_table,
  input  wire logic [HALL_BITS-1:0]  prev_hall,
  input  wire logic [HALL_BITS-1:0]  hall_code,
  input  wire logic                  forward_command,
  input  wire logic                  drive_enable,
  output hct_decode_t                decode
);

  logic [HALL_BITS-1:0] entries [HALL_ENTRIES];
  logic [HALL_BITS-1:0] ordered [HALL_ENTRIES];
  logic                 found;
  logic                 fwd_hit;
  logic                 rev_hit;

  always_comb begin
    for (int i = 0; i < HALL_ENTRIES; i++) begin
      entries[i] = hall_table[i*HALL_BITS +: HALL_BITS];
    end
    for (int j = 0; j < HALL_ENTRIES; j++) begin
      ordered[j] = forward_command ? entries[j] : entries[(j + 3) % HALL_ENTRIES];
    end
  end

  // first matching entry wins: scan from the top so the lowest index lands last
  always_comb begin
    found   = 1'b0;
    fwd_hit = 1'b0;
    rev_hit = 1'b0;
    for (int i = HALL_ENTRIES - 1; i >= 0; i--) begin
      if (entries[i] == prev_hall) begin
        found   = 1'b1;
        fwd_hit = (hall_code == entries[(i + 1) % HALL_ENTRIES]);
        rev_hit = (hall_code == entries[(i + HALL_ENTRIES - 1) % HALL_ENTRIES]);
      end
    end
  end

  always_comb begin
    decode.drive_hit = 1'b0;
    decode.drive_sel = '0;
    for (int j = HALL_ENTRIES - 1; j >= 0; j--) begin
      if (ordered[j] == hall_code) begin
        decode.drive_hit = drive_enable;
        decode.drive_sel = 3'(j);
      end
    end
    if (found && fwd_hit) begin
      decode.kind = STEP_FORWARD;
    end else if (found && rev_hit) begin
      decode.kind = STEP_REVERSE;
    end else begin
      decode.kind = STEP_INVALID;
    end
  end

endmodule

`default_nettype wire
